[rtl/core/cec_pkg.sv]
// cec_pkg: types, constants and the fraction table of the congestion edge cost block
// used by cec_exp2, congestion_edge_cost and cec_checker; depends on nothing
package cec_pkg;

    localparam int DIST_BITS    = 48;
    localparam int TRACK_BITS   = 16;
    localparam int LEN_BITS     = 32;
    localparam int HIST_BITS    = 32;
    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 8;
    localparam int CONG_BITS    = 24;
    localparam int YMAG_BITS    = 33;
    localparam int DVS_BITS     = 34;
    localparam int SIG_BITS     = 17;
    localparam int COST_BITS    = 25;
    localparam int SCALED_BITS  = 41;

    // cycles from an accepted transaction to its result strobe
    localparam int LATENCY = 27;

    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOPE = 8'd1;

    localparam logic [CFG_BITS-1:0] GAIN_RESET  = 16'd256;
    localparam logic [CFG_BITS-1:0] SLOPE_RESET = 16'd2560;

    localparam logic [DIST_BITS-1:0] DIST_MAX  = '1;
    localparam logic [CONG_BITS-1:0] CONG_MAX  = 24'(255 * 65536);
    localparam logic [CONG_BITS-1:0] ONE_CONG  = 24'd65536;
    localparam logic [16:0]          LOG2E_Q16 = 17'd94548;

    typedef struct packed {
        logic [DIST_BITS-1:0]  source_distance;
        logic [LEN_BITS-1:0]   edge_length;
        logic [TRACK_BITS-1:0] occupancy;
        logic [TRACK_BITS-1:0] capacity;
        logic [HIST_BITS-1:0]  history_cost;
    } cec_item_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] new_distance;
        logic                 unreached;
    } cec_result_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] src;
        logic [LEN_BITS-1:0]  len;
        logic [HIST_BITS-1:0] hist;
        logic                 blocked;
    } cec_side_t;

    // 2^(j/16) in Q16
    function automatic logic [17:0] pow2_frac(input logic [4:0] j);
        logic [17:0] v;
        unique case (j)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/cec_div_pipe.sv]
// cec_div_pipe: pipelined restoring divider, SPS quotient bits per stage, side data alongside
// depends on nothing; instantiated twice by congestion_edge_cost
module cec_div_pipe #(
    parameter int QW  = 24,
    parameter int RW  = 17,
    parameter int SW  = 1,
    parameter int SPS = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [RW-1:0] in_rem,
    input  logic [RW-1:0] in_dvs,
    input  logic [QW-1:0] in_num,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    localparam int NS = (QW + SPS - 1) / SPS;

    logic          valid_reg [NS];
    logic [RW-1:0] rem_reg   [NS];
    logic [RW-1:0] dvs_reg   [NS];
    logic [QW-1:0] num_reg   [NS];
    logic [QW-1:0] quo_reg   [NS];
    logic [SW-1:0] side_reg  [NS];

    genvar k;
    for (k = 0; k < NS; k++) begin : g_stage
        logic          vi;
        logic [RW-1:0] ri;
        logic [RW-1:0] di;
        logic [QW-1:0] ni;
        logic [QW-1:0] qi;
        logic [SW-1:0] si;
        logic [RW-1:0] rem_next;
        logic [QW-1:0] num_next;
        logic [QW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign vi = in_valid;
            assign ri = in_rem;
            assign di = in_dvs;
            assign ni = in_num;
            assign qi = '0;
            assign si = in_side;
        end else begin : g_rest
            assign vi = valid_reg[k-1];
            assign ri = rem_reg[k-1];
            assign di = dvs_reg[k-1];
            assign ni = num_reg[k-1];
            assign qi = quo_reg[k-1];
            assign si = side_reg[k-1];
        end

        always_comb
        begin
            rem_next = ri;
            num_next = ni;
            quo_next = qi;
            for (int t = 0; t < SPS; t++)
            begin
                if (k * SPS + t < QW)
                begin
                    rem_next = {rem_next[RW-2:0], num_next[QW-1]};
                    num_next = {num_next[QW-2:0], 1'b0};
                    if (rem_next >= di)
                    begin
                        rem_next = rem_next - di;
                        quo_next = {quo_next[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next = {quo_next[QW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            dvs_reg[k]  <= di;
            num_reg[k]  <= num_next;
            quo_reg[k]  <= quo_next;
            side_reg[k] <= si;
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

[rtl/core/cec_exp2.sv]
// cec_exp2: three-stage power of two on a signed Q.16 exponent, gives the divisor 1 + 2^y in Q16
// depends on cec_pkg (pow2_frac, widths)
module cec_exp2 #(
    parameter int SW = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [cec_pkg::YMAG_BITS-1:0]  ymag,
    input  logic                           neg,
    input  logic [SW-1:0]                  in_side,
    output logic                           out_valid,
    output logic [cec_pkg::DVS_BITS-1:0]   dvs,
    output logic [SW-1:0]                  out_side
);

    logic [16:0] ipart;
    logic [15:0] fmag;
    logic [15:0] frac;
    logic [17:0] down;
    logic [4:0]  shift_next;
    logic        force_next;

    logic          v1_reg;
    logic          neg1_reg;
    logic          force1_reg;
    logic [4:0]    shift1_reg;
    logic [3:0]    j1_reg;
    logic [11:0]   r1_reg;
    logic [SW-1:0] side1_reg;

    logic [17:0] p_lo;
    logic [17:0] p_hi;
    logic [29:0] interp;
    logic [17:0] p_next;

    logic          v2_reg;
    logic          neg2_reg;
    logic          force2_reg;
    logic [4:0]    shift2_reg;
    logic [17:0]   p2_reg;
    logic [SW-1:0] side2_reg;

    logic [cec_pkg::DVS_BITS-1:0] dvs_next;

    logic                         v3_reg;
    logic [cec_pkg::DVS_BITS-1:0] dvs_reg;
    logic [SW-1:0]                side3_reg;

    // split the exponent into integer shift and fraction
    always_comb
    begin
        ipart = ymag[32:16];
        fmag  = ymag[15:0];
        down  = 18'(ipart);
        frac  = fmag;
        if (!neg)
        begin
            force_next = (ipart >= 17'd16);
            shift_next = ipart[4:0];
        end
        else
        begin
            if (fmag != 16'd0)
            begin
                down = 18'(ipart) + 18'd1;
                frac = 16'(~fmag) + 16'd1;
            end
            force_next = (down >= 18'd18);
            shift_next = down[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        neg1_reg   <= neg;
        force1_reg <= force_next;
        shift1_reg <= shift_next;
        j1_reg     <= frac[15:12];
        r1_reg     <= frac[11:0];
        side1_reg  <= in_side;
    end

    // table lookup and linear interpolation
    always_comb
    begin
        p_lo   = cec_pkg::pow2_frac({1'b0, j1_reg});
        p_hi   = cec_pkg::pow2_frac({1'b0, j1_reg} + 5'd1);
        interp = 30'(p_hi - p_lo) * 30'(r1_reg);
        p_next = p_lo + 18'(interp >> 12);
    end

    always_ff @(posedge clk)
    begin
        neg2_reg   <= neg1_reg;
        force2_reg <= force1_reg;
        shift2_reg <= shift1_reg;
        p2_reg     <= p_next;
        side2_reg  <= side1_reg;
    end

    // scale by the integer part; a huge positive exponent forces a zero quotient, a huge negative one a divisor of 1
    always_comb
    begin
        if (!neg2_reg)
        begin
            if (force2_reg)
            begin
                dvs_next = '1;
            end
            else
            begin
                dvs_next = 34'd65536 + (34'(p2_reg) << shift2_reg);
            end
        end
        else
        begin
            if (force2_reg)
            begin
                dvs_next = 34'd65536;
            end
            else
            begin
                dvs_next = 34'd65536 + 34'(p2_reg >> shift2_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg   <= dvs_next;
        side3_reg <= side2_reg;
    end

    assign out_valid = v3_reg;
    assign dvs       = dvs_reg;
    assign out_side  = side3_reg;

endmodule

[rtl/core/congestion_edge_cost.sv]
// congestion_edge_cost: top level, edge relaxation cost of a negotiated-congestion router
// depends on cec_pkg, cec_div_pipe, cec_exp2
//
// Usage:
//   A transaction enters on item when start is high and busy is low. busy stays low,
//   so one transaction can enter in every clock cycle.
//   Each result appears on result for one cycle with done high, in the order the
//   transactions came in.
//   The pipeline is built around two pipelined dividers: the congestion ratio (8 stages,
//   three quotient bits each) and the sigmoid reciprocal (9 stages, two bits each), with
//   the multiply and exponent stages between them and the saturating add stages after.
//   Throughput is one transaction per cycle.
//   Configuration: cfg_we with cfg_index 0 writes the gain, index 1 the slope, other
//   indexes are ignored; write only while no transaction is in flight.
//   Reset clears all stage valid bits and loads gain 256 and slope 2560; results in
//   flight are dropped. The receiver cannot stall, so there is no backpressure path.
module congestion_edge_cost (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  cec_pkg::cec_item_t               item,
    output logic                             done,
    output cec_pkg::cec_result_t             result,
    input  logic                             cfg_we,
    input  logic [cec_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [cec_pkg::CFG_BITS-1:0]     cfg_wdata
);

    localparam int SIDE_BITS = $bits(cec_pkg::cec_side_t);
    localparam int TB        = cec_pkg::TRACK_BITS;
    localparam int DB        = cec_pkg::DIST_BITS;
    localparam int SB        = cec_pkg::SCALED_BITS;
    localparam int ADD_BITS  = ((DB > SB) ? DB : SB) + 1;
    localparam int HADD_BITS = ((DB > cec_pkg::HIST_BITS) ? DB : cec_pkg::HIST_BITS) + 1;

    logic [cec_pkg::CFG_BITS-1:0] gain_reg;
    logic [cec_pkg::CFG_BITS-1:0] slope_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= cec_pkg::GAIN_RESET;
            slope_reg <= cec_pkg::SLOPE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cec_pkg::REG_GAIN:
                begin
                    gain_reg <= cfg_wdata;
                end
                cec_pkg::REG_SLOPE:
                begin
                    slope_reg <= cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign busy = 1'b0;

    logic                accept;
    cec_pkg::cec_side_t  side_in;
    logic                sat_in;
    logic [TB:0]         div1_rem;
    logic [TB:0]         div1_dvs;
    logic [23:0]         div1_num;

    assign accept           = start && !busy;
    assign side_in.src      = item.source_distance;
    assign side_in.len      = item.edge_length;
    assign side_in.hist     = item.history_cost;
    assign side_in.blocked  = (item.capacity == '0);
    assign sat_in           = ({8'd0, item.occupancy} >= {item.capacity, 8'd0});
    assign div1_rem         = (TB + 1)'(item.occupancy >> 8);
    assign div1_dvs         = {1'b0, item.capacity};
    assign div1_num         = {item.occupancy[7:0], 16'd0};

    logic                            div1_valid;
    logic [cec_pkg::CONG_BITS-1:0]   div1_quo;
    logic [SIDE_BITS:0]              div1_side;

    cec_div_pipe #(
        .QW  (cec_pkg::CONG_BITS),
        .RW  (TB + 1),
        .SW  (SIDE_BITS + 1),
        .SPS (3)
    ) u_div_cong (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_rem    (div1_rem),
        .in_dvs    (div1_dvs),
        .in_num    (div1_num),
        .in_side   ({side_in, sat_in}),
        .out_valid (div1_valid),
        .out_quo   (div1_quo),
        .out_side  (div1_side)
    );

    // congestion clamp and distance from full occupancy
    logic [cec_pkg::CONG_BITS-1:0] cong;
    logic                          neg_next;
    logic [cec_pkg::CONG_BITS-1:0] dmag_next;

    always_comb
    begin
        if (div1_side[0] || div1_quo > cec_pkg::CONG_MAX)
        begin
            cong = cec_pkg::CONG_MAX;
        end
        else
        begin
            cong = div1_quo;
        end
        neg_next  = (cong < cec_pkg::ONE_CONG);
        dmag_next = neg_next ? (cec_pkg::ONE_CONG - cong) : (cong - cec_pkg::ONE_CONG);
    end

    logic                          vb_reg;
    logic                          negb_reg;
    logic [cec_pkg::CONG_BITS-1:0] dmagb_reg;
    cec_pkg::cec_side_t            sideb_reg;

    logic                          vc_reg;
    logic                          negc_reg;
    logic [31:0]                   xmagc_reg;
    cec_pkg::cec_side_t            sidec_reg;

    logic                          vd_reg;
    logic                          negd_reg;
    logic [cec_pkg::YMAG_BITS-1:0] ymagd_reg;
    cec_pkg::cec_side_t            sided_reg;

    logic [39:0] xprod;
    logic [48:0] yprod;

    assign xprod = 40'(slope_reg) * 40'(dmagb_reg);
    assign yprod = 49'(xmagc_reg) * 49'(cec_pkg::LOG2E_Q16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= div1_valid;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        negb_reg  <= neg_next;
        dmagb_reg <= dmag_next;
        sideb_reg <= div1_side[SIDE_BITS:1];
        negc_reg  <= negb_reg;
        xmagc_reg <= 32'(xprod >> 8);
        sidec_reg <= sideb_reg;
        negd_reg  <= negc_reg;
        ymagd_reg <= 33'(yprod >> 16);
        sided_reg <= sidec_reg;
    end

    logic                         exp_valid;
    logic [cec_pkg::DVS_BITS-1:0] exp_dvs;
    logic [SIDE_BITS-1:0]         exp_side;

    cec_exp2 #(
        .SW (SIDE_BITS)
    ) u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vd_reg),
        .ymag      (ymagd_reg),
        .neg       (negd_reg),
        .in_side   (sided_reg),
        .out_valid (exp_valid),
        .dvs       (exp_dvs),
        .out_side  (exp_side)
    );

    logic                         div2_valid;
    logic [cec_pkg::SIG_BITS-1:0] div2_quo;
    logic [SIDE_BITS-1:0]         div2_side;

    cec_div_pipe #(
        .QW  (cec_pkg::SIG_BITS),
        .RW  (cec_pkg::DVS_BITS),
        .SW  (SIDE_BITS),
        .SPS (2)
    ) u_div_sig (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (exp_valid),
        .in_rem    (34'd32768),
        .in_dvs    (exp_dvs),
        .in_num    ('0),
        .in_side   (exp_side),
        .out_valid (div2_valid),
        .out_quo   (div2_quo),
        .out_side  (div2_side)
    );

    cec_pkg::cec_side_t div2_side_s;
    assign div2_side_s = div2_side;

    logic                          vh_reg;
    logic [cec_pkg::COST_BITS-1:0] costh_reg;
    cec_pkg::cec_side_t            sideh_reg;

    logic                          vi_reg;
    logic [SB-1:0]                 scaledi_reg;
    cec_pkg::cec_side_t            sidei_reg;

    logic                          vj_reg;
    logic [DB-1:0]                 distj_reg;
    cec_pkg::cec_side_t            sidej_reg;

    logic                          done_reg;
    cec_pkg::cec_result_t          result_reg;

    logic [32:0]                   hprod;
    logic [56:0]                   lprod;
    logic [ADD_BITS-1:0]           sum1;
    logic [DB-1:0]                 dist1_next;
    logic [HADD_BITS-1:0]          sum2;
    cec_pkg::cec_result_t          result_next;

    assign hprod = 33'(gain_reg) * 33'(div2_quo);
    assign lprod = 57'(costh_reg) * 57'(sideh_reg.len);

    always_comb
    begin
        sum1 = ADD_BITS'(sidei_reg.src) + ADD_BITS'(scaledi_reg);
        if (sum1 > ADD_BITS'(cec_pkg::DIST_MAX))
        begin
            dist1_next = cec_pkg::DIST_MAX;
        end
        else
        begin
            dist1_next = DB'(sum1);
        end
    end

    always_comb
    begin
        sum2 = HADD_BITS'(distj_reg) + HADD_BITS'(sidej_reg.hist);
        result_next.unreached = sidej_reg.blocked;
        if (sidej_reg.blocked || sum2 > HADD_BITS'(cec_pkg::DIST_MAX))
        begin
            result_next.new_distance = cec_pkg::DIST_MAX;
        end
        else
        begin
            result_next.new_distance = DB'(sum2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vh_reg   <= 1'b0;
            vi_reg   <= 1'b0;
            vj_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vh_reg   <= div2_valid;
            vi_reg   <= vh_reg;
            vj_reg   <= vi_reg;
            done_reg <= vj_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        costh_reg   <= 25'd65536 + 25'(hprod >> 8);
        sideh_reg   <= div2_side_s;
        scaledi_reg <= SB'(lprod >> 16);
        sidei_reg   <= sideh_reg;
        distj_reg   <= dist1_next;
        sidej_reg   <= sidei_reg;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/core/cec_checker.sv]
// cec_checker: port-level assertions for congestion_edge_cost, bound to the top level
// depends on cec_pkg (LATENCY, types, DIST_MAX)
module cec_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input cec_pkg::cec_item_t   item,
    input logic                 done,
    input cec_pkg::cec_result_t result
);

    localparam int LAT = cec_pkg::LATENCY;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result strobe missing after a transaction");

    a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.capacity == '0) |-> ##LAT (done && result.unreached))
        else $error("blocked edge not flagged");

    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.capacity != '0) |-> ##LAT (done && !result.unreached))
        else $error("open edge flagged unreached");

    a_blocked_max: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.unreached) |-> (result.new_distance == cec_pkg::DIST_MAX))
        else $error("unreached result without maximum distance");

endmodule

bind congestion_edge_cost cec_checker u_cec_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
